// ----- sv/magnetorquer_phase_controller_defines.svh -----
// Assertion macros used by the magnetorquer phase controller checker.
`ifndef MAGNETORQUER_PHASE_CONTROLLER_DEFINES_SVH
`define MAGNETORQUER_PHASE_CONTROLLER_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define MPC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define MPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/mpc_pkg.sv -----
// Types, codes and helper functions of the magnetorquer phase controller.
package mpc_pkg;

    localparam int TIMER_BITS_DEF = 20;
    localparam int LEN_W          = 20;
    localparam int CMD_W          = 8;
    localparam int DUTY_W         = 7;
    localparam int MODE_W         = 3;
    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 32;
    localparam int S_TDATA_W      = 32;
    localparam int S_TUSER_W      = 2;
    localparam int M_TDATA_W      = 56;

    localparam logic [DUTY_W-1:0] DUTY_OFF = 7'd100;
    localparam logic [MODE_W-1:0] MODE_UNKNOWN = 3'd7;

    typedef enum logic [1:0] {
        PH_MEASURE = 2'd0,
        PH_FSW     = 2'd1,
        PH_BDOT    = 2'd2,
        PH_STAB    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_BDOT = 2'd1,
        REQ_FSW  = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        SRC_NONE = 2'd0,
        SRC_BDOT = 2'd1,
        SRC_FSW  = 2'd2
    } t_src;

    localparam logic [1:0] ACKPH_MEASURE = 2'd0;
    localparam logic [1:0] ACKPH_ACTIVE  = 2'd1;
    localparam logic [1:0] ACKPH_MAGNET  = 2'd2;

    typedef enum logic [2:0] {
        REG_MEASURE_TICKS   = 3'd0,
        REG_ACTUATE_TICKS   = 3'd1,
        REG_STABILIZE_TICKS = 3'd2,
        REG_IGNORE_FSW      = 3'd3,
        REG_POLARITY        = 3'd4,
        REG_PMS_ENABLE      = 3'd5,
        REG_PMS_DIPOLES     = 3'd6
    } t_reg_idx;

    typedef logic signed [CMD_W-1:0] t_cmd;
    typedef t_cmd [2:0]              t_vec;
    typedef logic [5:0][DUTY_W-1:0]  t_duty;

    // True when every axis lies within -100..100.
    function automatic logic vec_ok(input t_vec v);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (v[i] > 8'sd100 || v[i] < -8'sd100) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    // Chopping-mode duties of one axis as {two, one}.
    function automatic logic [2*DUTY_W-1:0] axis_duty(input t_cmd c, input logic neg);
        logic signed [CMD_W:0] p;
        logic [DUTY_W-1:0]     one;
        logic [DUTY_W-1:0]     two;
        p = neg ? -(CMD_W+1)'(c) : (CMD_W+1)'(c);
        if (p >= 0) begin
            one = DUTY_OFF - DUTY_W'(p);
            two = DUTY_OFF;
        end else begin
            one = DUTY_OFF;
            two = DUTY_OFF - DUTY_W'(-p);
        end
        return {two, one};
    endfunction

endpackage

// ----- sv/magnetorquer_phase_controller.sv -----
// Magnetorquer phase controller: phase sequencer and three-axis coil duty driver.
//
//  channel | direction | handshake                       | contents
//  --------+-----------+---------------------------------+---------------------------------
//  s_axis  | in        | i_s_axis_tvalid/o_s_axis_tready | request beat (tick or command)
//  m_axis  | out       | o_m_axis_tvalid/i_m_axis_tready | duties, phase and acknowledge
//  apb     | in        | psel, penable, pwrite, pready   | configuration registers
//
// One beat is accepted per cycle unless the output stalls; its result appears in the output register in the next cycle.
// The output register is the only stage, so a beat is taken whenever it is empty or drained.
// Reset is synchronous and sets state, registers and duties to their reset values.
// A stalled output holds its beat and holds off the input for that cycle.
module magnetorquer_phase_controller
    import mpc_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // cmd_x[7:0], cmd_y[15:8], cmd_z[23:16], mode_in[26:24], zeros above
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // req_type[1:0]
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // duty_x_one[6:0], duty_x_two[13:7], duty_y_one[20:14], duty_y_two[27:21],
    // duty_z_one[34:28], duty_z_two[41:35], phase_now[43:42], ack_pulse[44],
    // ack_phase[46:45], ack_source[48:47], zeros above
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int CMP_W = (TIMER_BITS > LEN_W) ? TIMER_BITS : LEN_W;
    localparam logic [TIMER_BITS-1:0] CNT_MAX = {TIMER_BITS{1'b1}};

    // Configuration registers
    logic [LEN_W-1:0] r_measure_ticks;
    logic [LEN_W-1:0] r_actuate_ticks;
    logic [LEN_W-1:0] r_stabilize_ticks;
    logic             r_ignore_fsw;
    logic [2:0]       r_polarity;
    logic             r_pms_enable;
    logic [23:0]      r_pms_dipoles;

    // Controller state
    t_phase                r_phase,   n_phase;
    logic [TIMER_BITS-1:0] r_elapsed, n_elapsed;
    t_vec                  r_bdot,    n_bdot;
    t_vec                  r_fsw,     n_fsw;
    logic [MODE_W-1:0]     r_mode,    n_mode;
    logic                  r_alive,   n_alive;
    t_src                  r_src,     n_src;
    t_duty                 r_duty,    n_duty;

    logic                  r_out_valid;
    logic [M_TDATA_W-1:0]  r_out_data, n_out_data;

    logic                  in_fire;
    logic                  cfg_wr;
    t_req                  req;
    t_vec                  in_vec;
    t_vec                  pm_vec;
    t_vec                  drv_vec;
    logic                  drv_on;
    logic                  drv_upd;
    logic [TIMER_BITS-1:0] elapsed_inc;
    logic [LEN_W-1:0]      len;
    logic                  done;
    logic                  ack;
    logic [1:0]            ack_ph;
    t_src                  ack_src;

    assign pready          = 1'b1;
    assign cfg_wr          = psel && penable && pwrite && pready;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign req       = t_req'(i_s_axis_tuser);
    assign in_vec[0] = i_s_axis_tdata[7:0];
    assign in_vec[1] = i_s_axis_tdata[15:8];
    assign in_vec[2] = i_s_axis_tdata[23:16];
    assign pm_vec[0] = r_pms_dipoles[7:0];
    assign pm_vec[1] = r_pms_dipoles[15:8];
    assign pm_vec[2] = r_pms_dipoles[23:16];

    always_comb begin
        case (t_reg_idx'(paddr[4:2]))
            REG_MEASURE_TICKS:   prdata = PDATA_W'(r_measure_ticks);
            REG_ACTUATE_TICKS:   prdata = PDATA_W'(r_actuate_ticks);
            REG_STABILIZE_TICKS: prdata = PDATA_W'(r_stabilize_ticks);
            REG_IGNORE_FSW:      prdata = PDATA_W'(r_ignore_fsw);
            REG_POLARITY:        prdata = PDATA_W'(r_polarity);
            REG_PMS_ENABLE:      prdata = PDATA_W'(r_pms_enable);
            REG_PMS_DIPOLES:     prdata = PDATA_W'(r_pms_dipoles);
            default:             prdata = '0;
        endcase
    end

    // Tick timer: the count saturates, and a saturated count also ends the phase.
    assign elapsed_inc = (r_elapsed == CNT_MAX) ? CNT_MAX : r_elapsed + 1'b1;

    always_comb begin
        case (r_phase)
            PH_MEASURE: len = r_measure_ticks;
            PH_STAB:    len = r_stabilize_ticks;
            default:    len = r_actuate_ticks;
        endcase
    end

    assign done = (CMP_W'(elapsed_inc) >= CMP_W'(len)) || (elapsed_inc == CNT_MAX);

    // Source vector for the coils on a tick.
    always_comb begin
        drv_vec = r_fsw;
        drv_on  = 1'b0;
        drv_upd = 1'b0;
        case (r_phase)
            PH_FSW: begin
                drv_upd = 1'b1;
                drv_on  = vec_ok(r_fsw);
            end
            PH_BDOT: begin
                drv_upd = 1'b1;
                if (vec_ok(r_bdot) && r_alive && !r_pms_enable) begin
                    drv_vec = r_bdot;
                    drv_on  = 1'b1;
                end else if (r_pms_enable && vec_ok(pm_vec)) begin
                    drv_vec = pm_vec;
                    drv_on  = 1'b1;
                end
            end
            PH_STAB: begin
                drv_upd = 1'b1;
            end
            default: begin
                drv_upd = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        n_bdot    = r_bdot;
        n_fsw     = r_fsw;
        n_mode    = r_mode;
        n_alive   = r_alive;
        n_src     = r_src;
        n_duty    = r_duty;
        ack       = 1'b0;
        ack_ph    = ACKPH_MEASURE;
        ack_src   = SRC_NONE;
        case (req)
            REQ_BDOT: begin
                n_bdot  = in_vec;
                n_alive = 1'b1;
                n_src   = SRC_BDOT;
            end
            REQ_FSW: begin
                n_fsw  = in_vec;
                n_mode = i_s_axis_tdata[26:24];
                n_src  = SRC_FSW;
            end
            REQ_TICK: begin
                n_elapsed = elapsed_inc;
                if (drv_upd) begin
                    for (int a = 0; a < 3; a++) begin
                        if (drv_on) begin
                            {n_duty[2*a+1], n_duty[2*a]} =
                                axis_duty(drv_vec[a], r_polarity[a]);
                        end else begin
                            n_duty[2*a]   = DUTY_OFF;
                            n_duty[2*a+1] = DUTY_OFF;
                        end
                    end
                end
                if (done) begin
                    case (r_phase)
                        PH_MEASURE: begin
                            n_phase = (r_mode[2:1] == 2'b00 && !r_ignore_fsw) ? PH_FSW
                                                                             : PH_BDOT;
                        end
                        PH_FSW: n_phase = PH_STAB;
                        PH_BDOT: begin
                            n_alive = 1'b0;
                            n_phase = r_pms_enable ? PH_BDOT : PH_STAB;
                        end
                        default: n_phase = PH_MEASURE;
                    endcase
                    n_elapsed = '0;
                    ack       = 1'b1;
                    ack_src   = r_src;
                    if (r_pms_enable) begin
                        ack_ph = ACKPH_MAGNET;
                    end else if (n_phase == PH_MEASURE) begin
                        ack_ph = ACKPH_MEASURE;
                    end else begin
                        ack_ph = ACKPH_ACTIVE;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        n_out_data = M_TDATA_W'({ack_src, ack_ph, ack, n_phase, n_duty});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_measure_ticks   <= LEN_W'(500);
            r_actuate_ticks   <= LEN_W'(1000);
            r_stabilize_ticks <= LEN_W'(500);
            r_ignore_fsw      <= 1'b0;
            r_polarity        <= '0;
            r_pms_enable      <= 1'b0;
            r_pms_dipoles     <= '0;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_MEASURE_TICKS:   r_measure_ticks   <= pwdata[LEN_W-1:0];
                REG_ACTUATE_TICKS:   r_actuate_ticks   <= pwdata[LEN_W-1:0];
                REG_STABILIZE_TICKS: r_stabilize_ticks <= pwdata[LEN_W-1:0];
                REG_IGNORE_FSW:      r_ignore_fsw      <= pwdata[0];
                REG_POLARITY:        r_polarity        <= pwdata[2:0];
                REG_PMS_ENABLE:      r_pms_enable      <= pwdata[0];
                REG_PMS_DIPOLES:     r_pms_dipoles     <= pwdata[23:0];
                default:             r_pms_dipoles     <= r_pms_dipoles;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MEASURE;
            r_elapsed   <= '0;
            r_bdot      <= '0;
            r_fsw       <= '0;
            r_mode      <= MODE_UNKNOWN;
            r_alive     <= 1'b0;
            r_src       <= SRC_NONE;
            r_duty      <= {6{DUTY_OFF}};
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase   <= n_phase;
                r_elapsed <= n_elapsed;
                r_bdot    <= n_bdot;
                r_fsw     <= n_fsw;
                r_mode    <= n_mode;
                r_alive   <= n_alive;
                r_src     <= n_src;
                r_duty    <= n_duty;
            end
            if (o_s_axis_tready) begin
                r_out_valid <= i_s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ----- sv/mpc_checker.sv -----
// Port-level checker for the magnetorquer phase controller, bound to the top level.
`include "magnetorquer_phase_controller_defines.svh"

module mpc_checker
    import mpc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_s_axis_tready,
    input logic                 o_m_axis_tvalid,
    input logic                 i_m_axis_tready,
    input logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    `MPC_ASSERT_ALWAYS(a_out_empty_after_reset, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "output beat present after reset")

    `MPC_ASSERT(a_out_holds, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled output beat changed")

    `MPC_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid |-> o_s_axis_tready, "input held off with an empty output register")

    `MPC_ASSERT(a_duty_range, i_clk, i_rst_n, o_m_axis_tvalid |-> (o_m_axis_tdata[6:0] <= 7'd100) && (o_m_axis_tdata[13:7] <= 7'd100) && (o_m_axis_tdata[20:14] <= 7'd100) && (o_m_axis_tdata[27:21] <= 7'd100) && (o_m_axis_tdata[34:28] <= 7'd100) && (o_m_axis_tdata[41:35] <= 7'd100), "coil duty above full scale")

    `MPC_ASSERT(a_quiet_ack, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tdata[44] |-> o_m_axis_tdata[48:45] == 4'd0, "acknowledge fields set without a pulse")

endmodule

bind magnetorquer_phase_controller mpc_checker u_mpc_checker (.*);

// ----- dv/magnetorquer_phase_controller_tb.sv -----
// Self-checking testbench for the magnetorquer phase controller.
`timescale 1ns / 1ps

module magnetorquer_phase_controller_tb;
    import mpc_pkg::*;

    localparam int unsigned ELAPSED_MAX = (1 << TIMER_BITS_DEF) - 1;
    localparam logic [LEN_W-1:0] LEN_LONGEST = '1;

    // Fields of one output beat, laid out as on o_m_axis_tdata.
    typedef struct packed {
        logic [1:0] ack_source;
        logic [1:0] ack_phase;
        logic       ack_pulse;
        logic [1:0] phase_now;
        t_duty      duty;
    } t_coil_status;

    class t_coil_scoreboard;
        logic [LEN_W-1:0]  measure_len;
        logic [LEN_W-1:0]  actuate_len;
        logic [LEN_W-1:0]  stabilize_len;
        logic              fsw_blocked;
        logic [2:0]        axis_flip;
        logic              magnet_mode;
        logic [23:0]       magnet_dipoles;
        t_phase            phase;
        int unsigned       elapsed;
        int                detumble_cmd[3];
        int                fsw_cmd[3];
        logic [MODE_W-1:0] fsw_mode;
        logic              detumble_fresh;
        t_src              source;
        t_duty             duty;
        t_coil_status      predicted[$];
        int                errors;

        function new();
            measure_len    = 500;
            actuate_len    = 1000;
            stabilize_len  = 500;
            fsw_blocked    = 1'b0;
            axis_flip      = '0;
            magnet_mode    = 1'b0;
            magnet_dipoles = '0;
            phase          = PH_MEASURE;
            elapsed        = 0;
            for (int a = 0; a < 3; a++) begin
                detumble_cmd[a] = 0;
                fsw_cmd[a]      = 0;
            end
            fsw_mode       = MODE_UNKNOWN;
            detumble_fresh = 1'b0;
            source         = SRC_NONE;
            coils_off();
            errors         = 0;
        endfunction

        function void set_register(t_reg_idx idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_MEASURE_TICKS:   measure_len    = value[LEN_W-1:0];
                REG_ACTUATE_TICKS:   actuate_len    = value[LEN_W-1:0];
                REG_STABILIZE_TICKS: stabilize_len  = value[LEN_W-1:0];
                REG_IGNORE_FSW:      fsw_blocked    = value[0];
                REG_POLARITY:        axis_flip      = value[2:0];
                REG_PMS_ENABLE:      magnet_mode    = value[0];
                REG_PMS_DIPOLES:     magnet_dipoles = value[23:0];
                default: ;
            endcase
        endfunction

        function bit in_range(input int v[3]);
            for (int a = 0; a < 3; a++) begin
                if (v[a] > 100 || v[a] < -100) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void coils_off();
            duty = {6{DUTY_OFF}};
        endfunction

        function void drive_coils(input int v[3]);
            int p;
            for (int a = 0; a < 3; a++) begin
                p = axis_flip[a] ? -v[a] : v[a];
                duty[2*a]   = (p >= 0) ? DUTY_W'(int'(DUTY_OFF) - p) : DUTY_OFF;
                duty[2*a+1] = (p < 0)  ? DUTY_W'(int'(DUTY_OFF) + p) : DUTY_OFF;
            end
        endfunction

        // Advances the controller by one accepted request and queues the beat it must produce.
        function void note_request(t_req req, logic [7:0] x, logic [7:0] y, logic [7:0] z,
                                   logic [MODE_W-1:0] mode);
            t_coil_status     st;
            int               magnet[3];
            logic [LEN_W-1:0] len;
            logic             done;
            st = '0;
            case (req)
                REQ_BDOT: begin
                    detumble_cmd[0] = $signed(x);
                    detumble_cmd[1] = $signed(y);
                    detumble_cmd[2] = $signed(z);
                    detumble_fresh  = 1'b1;
                    source          = SRC_BDOT;
                end
                REQ_FSW: begin
                    fsw_cmd[0] = $signed(x);
                    fsw_cmd[1] = $signed(y);
                    fsw_cmd[2] = $signed(z);
                    fsw_mode   = mode;
                    source     = SRC_FSW;
                end
                REQ_TICK: begin
                    if (elapsed < ELAPSED_MAX) begin
                        elapsed++;
                    end
                    case (phase)
                        PH_MEASURE: len = measure_len;
                        PH_STAB:    len = stabilize_len;
                        default:    len = actuate_len;
                    endcase
                    done = (elapsed >= len) || (elapsed >= ELAPSED_MAX);
                    case (phase)
                        PH_MEASURE: begin
                            if (done) begin
                                phase = (fsw_mode <= 3'd1 && !fsw_blocked) ? PH_FSW : PH_BDOT;
                            end
                        end
                        PH_FSW: begin
                            if (in_range(fsw_cmd)) begin
                                drive_coils(fsw_cmd);
                            end else begin
                                coils_off();
                            end
                            if (done) begin
                                phase = PH_STAB;
                            end
                        end
                        PH_BDOT: begin
                            magnet[0] = $signed(magnet_dipoles[7:0]);
                            magnet[1] = $signed(magnet_dipoles[15:8]);
                            magnet[2] = $signed(magnet_dipoles[23:16]);
                            if (in_range(detumble_cmd) && detumble_fresh && !magnet_mode) begin
                                drive_coils(detumble_cmd);
                            end else if (magnet_mode && in_range(magnet)) begin
                                drive_coils(magnet);
                            end else begin
                                coils_off();
                            end
                            if (done) begin
                                detumble_fresh = 1'b0;
                                phase = magnet_mode ? PH_BDOT : PH_STAB;
                            end
                        end
                        default: begin
                            coils_off();
                            if (done) begin
                                phase = PH_MEASURE;
                            end
                        end
                    endcase
                    if (done) begin
                        elapsed      = 0;
                        st.ack_pulse = 1'b1;
                        st.ack_phase = magnet_mode ? ACKPH_MAGNET
                                     : (phase == PH_MEASURE ? ACKPH_MEASURE : ACKPH_ACTIVE);
                        st.ack_source = source;
                    end
                end
                default: ;
            endcase
            st.duty      = duty;
            st.phase_now = phase;
            predicted.push_back(st);
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_status(logic [M_TDATA_W-1:0] bits);
            t_coil_status got;
            t_coil_status want;
            string        duty_names[6] = '{"duty_x_one", "duty_x_two", "duty_y_one",
                                            "duty_y_two", "duty_z_one", "duty_z_two"};
            got = bits[$bits(t_coil_status)-1:0];
            if (predicted.size() == 0) begin
                $display("%0t: output beat 0x%0h arrived with nothing predicted", $time, bits);
                errors++;
                return;
            end
            want = predicted.pop_front();
            for (int i = 0; i < 6; i++) begin
                check_field(duty_names[i], want.duty[i], got.duty[i]);
            end
            check_field("phase_now", want.phase_now, got.phase_now);
            check_field("ack_pulse", want.ack_pulse, got.ack_pulse);
            check_field("ack_phase", want.ack_phase, got.ack_phase);
            check_field("ack_source", want.ack_source, got.ack_source);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    t_coil_scoreboard sb;
    int               burst_left = 0;
    logic [31:0]      stall_count = '0;

    magnetorquer_phase_controller u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // The receiver cycles through always ready, light random stalls, a fixed stall
    // pattern and heavy random stalls.
    always @(posedge i_clk) begin
        stall_count <= stall_count + 1;
        case (stall_count[10:9])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    m_tready <= (stall_count[2:0] != 3'd5) && (stall_count[2:0] != 3'd6);
            default: m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            sb.check_status(m_tdata);
        end
    end

    task automatic write_register(t_reg_idx idx, logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_register(idx, value);
        @(posedge i_clk);
    endtask

    task automatic send_request(t_req req, logic [7:0] x, logic [7:0] y, logic [7:0] z,
                                logic [MODE_W-1:0] mode);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, mode, z, y, x};
        s_tuser  <= req;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sb.note_request(req, x, y, z, mode);
        burst_left--;
    endtask

    // Holds the input off until every predicted beat has been seen.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.predicted.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    function automatic logic [7:0] rand_cmd();
        int v;
        if ($urandom_range(0, 4) != 0) begin
            v = int'($urandom_range(0, 200)) - 100;
        end else begin
            v = $urandom_range(0, 255);
        end
        return v[7:0];
    endfunction

    function automatic logic [LEN_W-1:0] pick_len(int setting);
        if (setting == 0) begin
            return LEN_W'(1);
        end else if (setting == 1 || $urandom_range(0, 9) == 0) begin
            return '0;
        end
        return ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(8, 30))
                                           : LEN_W'($urandom_range(1, 7));
    endfunction

    initial begin
        int                k;
        t_req              req;
        logic [MODE_W-1:0] mode;
        logic [23:0]       dipoles;
        sb = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_register(REG_MEASURE_TICKS, 1);
        write_register(REG_ACTUATE_TICKS, 2);
        write_register(REG_STABILIZE_TICKS, 1);
        write_register(REG_IGNORE_FSW, 0);
        write_register(REG_POLARITY, 0);
        write_register(REG_PMS_ENABLE, 0);
        write_register(REG_PMS_DIPOLES, 0);

        // Unknown request, then a detumble pass with no fresh detumble vector.
        send_request(REQ_NONE, 8'hFF, 8'hFF, 8'hFF, 3'd7);
        send_request(REQ_TICK, 8'h00, 8'h00, 8'h00, 3'd0);
        send_request(REQ_TICK, 8'h00, 8'h00, 8'h00, 3'd0);
        send_request(REQ_BDOT, 8'd100, -8'sd100, 8'd0, 3'd0);
        send_request(REQ_TICK, 8'h00, 8'h00, 8'h00, 3'd0);
        send_request(REQ_TICK, 8'h00, 8'h00, 8'h00, 3'd0);
        // Flight software vector out of range, then a valid one mid-phase.
        send_request(REQ_FSW, 8'd127, 8'h80, 8'd0, 3'd0);
        send_request(REQ_TICK, 8'h00, 8'h00, 8'h00, 3'd0);
        send_request(REQ_TICK, 8'h00, 8'h00, 8'h00, 3'd0);
        send_request(REQ_FSW, -8'sd100, 8'd100, 8'hFF, 3'd1);
        send_request(REQ_TICK, 8'h00, 8'h00, 8'h00, 3'd0);
        send_request(REQ_TICK, 8'h00, 8'h00, 8'h00, 3'd0);
        // Bad detumble vector with the flight software mode unknown again.
        send_request(REQ_BDOT, -8'sd101, 8'd0, 8'd0, 3'd0);
        send_request(REQ_FSW, 8'd0, 8'd0, 8'd0, 3'd7);
        send_request(REQ_TICK, 8'h00, 8'h00, 8'h00, 3'd0);
        send_request(REQ_TICK, 8'h00, 8'h00, 8'h00, 3'd0);
        send_request(REQ_TICK, 8'h00, 8'h00, 8'h00, 3'd0);

        // Magnet mode with every axis negated; detumble expiry re-enters detumble.
        wait_drained();
        write_register(REG_POLARITY, 7);
        write_register(REG_PMS_DIPOLES, 32'h009C_64FF);
        write_register(REG_PMS_ENABLE, 1);
        repeat (5) send_request(REQ_TICK, 8'h00, 8'h00, 8'h00, 3'd0);

        // Longest phase lengths: the machine just counts.
        wait_drained();
        write_register(REG_MEASURE_TICKS, PDATA_W'(LEN_LONGEST));
        write_register(REG_ACTUATE_TICKS, PDATA_W'(LEN_LONGEST));
        write_register(REG_STABILIZE_TICKS, PDATA_W'(LEN_LONGEST));
        repeat (6) send_request(REQ_TICK, 8'h00, 8'h00, 8'h00, 3'd0);

        for (int setting = 0; setting < 10; setting++) begin
            wait_drained();
            case (setting)
                5:       dipoles = 24'hFFFFFF;
                7:       dipoles = 24'h9C649C;
                default: dipoles = {rand_cmd(), rand_cmd(), rand_cmd()};
            endcase
            write_register(REG_MEASURE_TICKS, PDATA_W'(pick_len(setting)));
            write_register(REG_ACTUATE_TICKS, PDATA_W'(pick_len(setting)));
            write_register(REG_STABILIZE_TICKS, PDATA_W'(pick_len(setting)));
            write_register(REG_IGNORE_FSW, (setting == 4) ? 1 : $urandom_range(0, 1));
            write_register(REG_POLARITY, (setting == 0) ? 0
                                       : (setting == 1) ? 7 : $urandom_range(0, 7));
            write_register(REG_PMS_ENABLE, (setting % 3 == 2) ? 1 : $urandom_range(0, 1));
            write_register(REG_PMS_DIPOLES, PDATA_W'(dipoles));
            for (int n = 0; n < 125; n++) begin
                if (n == 60 && setting % 2 == 1) begin
                    wait_drained();
                end
                k = $urandom_range(0, 99);
                if (k < 66) begin
                    req = REQ_TICK;
                end else if (k < 80) begin
                    req = REQ_BDOT;
                end else if (k < 94) begin
                    req = REQ_FSW;
                end else begin
                    req = REQ_NONE;
                end
                mode = $urandom_range(0, 1) ? MODE_W'($urandom_range(0, 1))
                                            : MODE_W'($urandom_range(0, 7));
                send_request(req, rand_cmd(), rand_cmd(), rand_cmd(), mode);
            end
        end

        s_tvalid <= 1'b0;
        while (sb.predicted.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.predicted.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #6_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/mpc_pkg.sv
sv/magnetorquer_phase_controller.sv
sv/mpc_checker.sv
dv/magnetorquer_phase_controller_tb.sv
